### design/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Boolean condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

### design/xed_pkg.sv
// Shared types and constants of the XML entity decoder.
package xed_pkg;

	localparam int unsigned MAX_RESULTS = 4;

	// Reset value of the byte limit register
	localparam logic [15:0] MAX_BYTES_RST = 16'd4096;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_UNTERM   = 3'd1,
		ERR_UNKNOWN  = 3'd2,
		ERR_BAD_REF  = 3'd3,
		ERR_TOO_LONG = 3'd4
	} xed_err_t;

	// Results caused by one input item, handed from core to output buffer
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] data;
		logic [2:0]                  cnt;
		logic                        eov;
		xed_err_t                    err;
	} xed_res_t;

endpackage

### design/xed_ifs.sv
// Valid/ready channel interfaces for raw bytes and decoded results.
interface xed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface xed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_value;
	logic [2:0] error_code;

	modport source (output valid, output out_byte, output end_of_value, output error_code,
		input ready);
	modport sink (input valid, input out_byte, input end_of_value, input error_code,
		output ready);
endinterface

### design/xed_core.sv
// Input register, entity state and single-pass decode of one raw byte.
`include "assert_macros.svh"

module xed_core (
	input  logic             clk,
	input  logic             arst_n,
	xed_in_if.sink           raw,
	input  logic [15:0]      max_value_bytes,
	input  logic             buf_free,
	output logic             res_load,
	output xed_pkg::xed_res_t res
);
	import xed_pkg::*;

	localparam logic [7:0]  CH_AMP   = 8'h26;
	localparam logic [7:0]  CH_SEMI  = 8'h3B;
	localparam logic [7:0]  CH_HASH  = 8'h23;
	localparam logic [7:0]  CH_LX    = 8'h78;
	localparam logic [7:0]  CH_UX    = 8'h58;
	localparam logic [7:0]  CH_LT    = 8'h3C;
	localparam logic [7:0]  CH_GT    = 8'h3E;
	localparam logic [7:0]  CH_QUOT  = 8'h22;
	localparam logic [7:0]  CH_APOS  = 8'h27;
	localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
	localparam logic [31:0] NAME_GT   = 32'h0000_6774;
	localparam logic [31:0] NAME_AMP  = 32'h0061_6D70;
	localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;
	localparam logic [31:0] NAME_APOS = 32'h6170_6F73;
	localparam logic [20:0] CODE_MAX  = 21'h10FFFF;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	// entity state
	logic        in_entity_q, in_entity_d;
	logic [2:0]  ent_len_q, ent_len_d;
	logic [31:0] name_q, name_d;
	logic        numeric_q, numeric_d;
	logic        hex_q, hex_d;
	logic        digit_q, digit_d;
	logic [20:0] accum_q, accum_d;
	logic        pend_q, pend_d;
	logic [16:0] emitted_q, emitted_d;
	logic        dropping_q, dropping_d;

	// digit step
	logic [4:0]  digit_val;
	logic [4:0]  base;
	logic [24:0] prod;

	// reference resolution
	logic                        ref_fail;
	xed_err_t                    ref_code;
	logic [2:0]                  enc_n;
	logic [MAX_RESULTS-1:0][7:0] enc_data;
	logic                        char_ok;
	logic                        plain_over;
	logic                        ent_over;

	logic     fail;
	xed_err_t fail_code;

	assign adv       = valid_s1 && buf_free;
	assign raw.ready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.in_byte;
			last_s1 <= raw.last;
		end
	end

	// Digit value; base itself marks a non-digit
	always_comb begin
		base = hex_q ? 5'd16 : 5'd10;
		digit_val = base;
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			digit_val = 5'(byte_s1 - 8'h30);
		end else if (hex_q && byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			digit_val = 5'(byte_s1 - 8'h57);
		end else if (hex_q && byte_s1 >= 8'h41 && byte_s1 <= 8'h46) begin
			digit_val = 5'(byte_s1 - 8'h37);
		end
		if (hex_q) begin
			prod = {accum_q, 4'b0} + {20'b0, digit_val};
		end else begin
			prod = {1'b0, accum_q, 3'b0} + {3'b0, accum_q, 1'b0} + {20'b0, digit_val};
		end
	end

	// XML Char ranges
	assign char_ok = accum_q == 21'h09 || accum_q == 21'h0A || accum_q == 21'h0D
		|| (accum_q >= 21'h20 && accum_q <= 21'hD7FF)
		|| (accum_q >= 21'hE000 && accum_q <= 21'hFFFD)
		|| (accum_q >= 21'h10000 && accum_q <= CODE_MAX);

	// Entity resolution and UTF-8 encoding
	always_comb begin
		ref_fail = 1'b0;
		ref_code = ERR_NONE;
		enc_n    = 3'd1;
		enc_data = '0;
		if (!numeric_q) begin
			if (ent_len_q == 3'd2 && name_q == NAME_LT) begin
				enc_data[0] = CH_LT;
			end else if (ent_len_q == 3'd2 && name_q == NAME_GT) begin
				enc_data[0] = CH_GT;
			end else if (ent_len_q == 3'd3 && name_q == NAME_AMP) begin
				enc_data[0] = CH_AMP;
			end else if (ent_len_q == 3'd4 && name_q == NAME_QUOT) begin
				enc_data[0] = CH_QUOT;
			end else if (ent_len_q == 3'd4 && name_q == NAME_APOS) begin
				enc_data[0] = CH_APOS;
			end else begin
				ref_fail = 1'b1;
				ref_code = ERR_UNKNOWN;
			end
		end else if (pend_q) begin
			ref_fail = 1'b1;
			ref_code = ERR_BAD_REF;
		end else if (!digit_q) begin
			ref_fail = 1'b1;
			ref_code = hex_q ? ERR_BAD_REF : ERR_UNKNOWN;
		end else if (!char_ok) begin
			ref_fail = 1'b1;
			ref_code = ERR_BAD_REF;
		end else if (accum_q <= 21'h7F) begin
			enc_data[0] = accum_q[7:0];
		end else if (accum_q <= 21'h7FF) begin
			enc_n       = 3'd2;
			enc_data[0] = {3'b110, accum_q[10:6]};
			enc_data[1] = {2'b10, accum_q[5:0]};
		end else if (accum_q <= 21'hFFFF) begin
			enc_n       = 3'd3;
			enc_data[0] = {4'b1110, accum_q[15:12]};
			enc_data[1] = {2'b10, accum_q[11:6]};
			enc_data[2] = {2'b10, accum_q[5:0]};
		end else begin
			enc_n       = 3'd4;
			enc_data[0] = {5'b11110, accum_q[20:18]};
			enc_data[1] = {2'b10, accum_q[17:12]};
			enc_data[2] = {2'b10, accum_q[11:6]};
			enc_data[3] = {2'b10, accum_q[5:0]};
		end
	end

	assign plain_over = ({1'b0, emitted_q} + 18'd1) > {2'b0, max_value_bytes};
	assign ent_over   = ({1'b0, emitted_q} + {15'b0, enc_n}) > {2'b0, max_value_bytes};

	always_comb begin
		in_entity_d = in_entity_q;
		ent_len_d   = ent_len_q;
		name_d      = name_q;
		numeric_d   = numeric_q;
		hex_d       = hex_q;
		digit_d     = digit_q;
		accum_d     = accum_q;
		pend_d      = pend_q;
		emitted_d   = emitted_q;
		dropping_d  = dropping_q;
		res         = '0;
		fail        = 1'b0;
		fail_code   = ERR_NONE;

		if (dropping_q) begin
			// discard until the final byte
		end else if (!in_entity_q) begin
			if (byte_s1 == CH_AMP) begin
				in_entity_d = 1'b1;
				if (last_s1) begin
					fail      = 1'b1;
					fail_code = ERR_UNTERM;
				end
			end else if (plain_over) begin
				fail      = 1'b1;
				fail_code = ERR_TOO_LONG;
			end else begin
				res.cnt     = 3'd1;
				res.data[0] = byte_s1;
				emitted_d   = emitted_q + 17'd1;
			end
		end else if (byte_s1 == CH_SEMI) begin
			if (ref_fail) begin
				fail      = 1'b1;
				fail_code = ref_code;
			end else if (ent_over) begin
				fail      = 1'b1;
				fail_code = ERR_TOO_LONG;
			end else begin
				res.cnt     = enc_n;
				res.data    = enc_data;
				emitted_d   = emitted_q + {14'b0, enc_n};
				in_entity_d = 1'b0;
				ent_len_d   = '0;
				name_d      = '0;
				numeric_d   = 1'b0;
				hex_d       = 1'b0;
				digit_d     = 1'b0;
				accum_d     = '0;
				pend_d      = 1'b0;
			end
		end else begin
			// entity character
			if (ent_len_q == 3'd0 && byte_s1 == CH_HASH) begin
				numeric_d = 1'b1;
			end else if (numeric_q) begin
				if (ent_len_q == 3'd1 && (byte_s1 == CH_LX || byte_s1 == CH_UX)) begin
					hex_d = 1'b1;
				end else begin
					digit_d = 1'b1;
					if (!pend_q) begin
						if (digit_val >= base || prod > {4'b0, CODE_MAX}) begin
							pend_d = 1'b1;
						end else begin
							accum_d = prod[20:0];
						end
					end
				end
			end else begin
				name_d = {name_q[23:0], byte_s1};
			end
			if (ent_len_q != 3'd7) begin
				ent_len_d = ent_len_q + 3'd1;
			end
			if (last_s1) begin
				fail      = 1'b1;
				fail_code = ERR_UNTERM;
			end
		end

		if (fail) begin
			res.cnt  = 3'd1;
			res.data = '0;
			res.eov  = 1'b1;
			res.err  = fail_code;
		end else begin
			res.eov = last_s1;
		end

		// value closes on the final byte or on an error
		if (fail || last_s1) begin
			in_entity_d = 1'b0;
			ent_len_d   = '0;
			name_d      = '0;
			numeric_d   = 1'b0;
			hex_d       = 1'b0;
			digit_d     = 1'b0;
			accum_d     = '0;
			pend_d      = 1'b0;
			emitted_d   = '0;
			dropping_d  = fail && !last_s1;
		end
	end

	assign res_load = adv && res.cnt != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_entity_q <= 1'b0;
			ent_len_q   <= '0;
			name_q      <= '0;
			numeric_q   <= 1'b0;
			hex_q       <= 1'b0;
			digit_q     <= 1'b0;
			accum_q     <= '0;
			pend_q      <= 1'b0;
			emitted_q   <= '0;
			dropping_q  <= 1'b0;
		end else if (adv) begin
			in_entity_q <= in_entity_d;
			ent_len_q   <= ent_len_d;
			name_q      <= name_d;
			numeric_q   <= numeric_d;
			hex_q       <= hex_d;
			digit_q     <= digit_d;
			accum_q     <= accum_d;
			pend_q      <= pend_d;
			emitted_q   <= emitted_d;
			dropping_q  <= dropping_d;
		end
	end

	`ASSERT_AT(a_drop_outside_entity, clk, arst_n, dropping_q |-> !in_entity_q, "dropping inside an entity")
	`ASSERT_AT(a_pend_numeric, clk, arst_n, pend_q |-> (numeric_q && in_entity_q), "held error outside a reference")
	`ASSERT_AT(a_accum_range, clk, arst_n, accum_q <= CODE_MAX, "code point above range")

endmodule

### design/xed_obuf.sv
// Result register that hands out the bytes of one decoded item one per cycle while decoded is ready.
`include "assert_macros.svh"

module xed_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  xed_pkg::xed_res_t res,
	output logic              free,
	xed_out_if.source         decoded
);
	import xed_pkg::*;

	logic [MAX_RESULTS-1:0][7:0] data_q;
	logic                        eov_q;
	xed_err_t                    err_q;
	logic [2:0]                  rem_q;
	logic [1:0]                  idx_q;
	logic                        fire;

	assign fire = decoded.valid && decoded.ready;
	assign free = rem_q == 3'd0 || (rem_q == 3'd1 && decoded.ready);

	assign decoded.valid        = rem_q != 3'd0;
	assign decoded.out_byte     = data_q[idx_q];
	assign decoded.end_of_value = eov_q && rem_q == 3'd1;
	assign decoded.error_code   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= res.cnt;
			idx_q <= '0;
		end else if (fire) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.data;
			eov_q  <= res.eov;
			err_q  <= res.err;
		end
	end

	`ASSERT_AT(a_rem_range, clk, arst_n, rem_q <= 3'd4, "result count above four")
	`ASSERT_NEVER(a_load_busy, clk, arst_n, load && !free, "load while results still pending")
	`ASSERT_AT(a_err_closes, clk, arst_n, (decoded.valid && err_q != ERR_NONE) |-> (decoded.end_of_value && decoded.out_byte == 8'h00), "error result not closing")

endmodule

### design/xml_entity_decoder_utf8.sv
// Top level of the XML attribute entity decoder with UTF-8 output.
//
//  channel   | dir | payload                              | handshake
//  ----------+-----+--------------------------------------+-------------------
//  raw       | in  | in_byte[7:0], last                   | valid/ready
//  decoded   | out | out_byte[7:0], end_of_value, err[2:0]| valid/ready
//  cfg       | in  | cfg_wdata[15:0] = max_value_bytes    | cfg_we, no ready
//
//  One raw item per cycle while the result register can take it; items pass
//  the input register, their results the result register. A closing ';' that
//  gives n UTF-8 bytes holds the input while decoded takes them one per cycle.
//  Reset clears all entity state; byte limit returns to 4096. No clear pass.
//  A stall on decoded backs up through the result register and input stage.
//
// Structure: input stage and entity state machine in xed_core, which works
// out every result byte of an item in one pass; xed_obuf holds up to four
// result bytes and presents them in order.

module xml_entity_decoder_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	xed_in_if.sink      raw,
	xed_out_if.source   decoded,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import xed_pkg::*;

	// byte limit register
	logic [15:0] max_bytes_q;

	// core to output buffer
	xed_res_t res;
	logic     res_load;
	logic     buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	// decode: one item per cycle when the result register can take it
	xed_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.raw             (raw),
		.max_value_bytes (max_bytes_q),
		.buf_free        (buf_free),
		.res_load        (res_load),
		.res             (res)
	);

	// result bytes out, one per cycle while decoded is ready
	xed_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_load),
		.res     (res),
		.free    (buf_free),
		.decoded (decoded)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for xml_entity_decoder_utf8: directed table, then random values.
module tb;
	import xed_pkg::*;

	// Generous bound: the raw bytes of all phases, with stalls on both sides, stay far below it
	localparam int unsigned CYCLE_LIMIT  = 200000;
	// Settling time after the last due result, before a limit change or the end
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CODE_TOP     = 32'h10FFFF;
	localparam int unsigned LONG_HOLD    = 300;

	// One decoded item as it leaves the block
	typedef struct packed {
		logic [7:0] data;
		logic       eov;
		xed_err_t   err;
	} dec_item_t;

	// How a table row is checked: against the predictor, no result at all,
	// or the single result typed into the row
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_TYPED
	} row_check_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		row_check_e chk;
		dec_item_t  want;
	} stim_row_t;

	localparam dec_item_t NO_ITEM = '{8'h00, 1'b0, ERR_NONE};

	// Directed part: field extremes, the lt entity, unterminated, unknown and bad
	// reference errors, dropping after an error, the top code point and '&' in an entity
	localparam stim_row_t DIR_ROWS [27] = '{
		'{8'h00, 1'b0, ROW_TYPED,   '{8'h00, 1'b0, ERR_NONE}},
		'{8'hFF, 1'b1, ROW_TYPED,   '{8'hFF, 1'b1, ERR_NONE}},
		// ampersand as the final byte: unterminated straight away
		'{"&",   1'b1, ROW_TYPED,   '{8'h00, 1'b1, ERR_UNTERM}},
		'{"&",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"l",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"t",   1'b0, ROW_SILENT,  NO_ITEM},
		'{";",   1'b1, ROW_TYPED,   '{"<",   1'b1, ERR_NONE}},
		// empty name mid-value, then the rest of the value is swallowed
		'{"&",   1'b0, ROW_SILENT,  NO_ITEM},
		'{";",   1'b0, ROW_TYPED,   '{8'h00, 1'b1, ERR_UNKNOWN}},
		'{"&",   1'b1, ROW_SILENT,  NO_ITEM},
		// hex marker with no digits
		'{"&",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"#",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"x",   1'b0, ROW_SILENT,  NO_ITEM},
		'{";",   1'b1, ROW_TYPED,   '{8'h00, 1'b1, ERR_BAD_REF}},
		// highest legal code point, four UTF-8 bytes
		'{"&",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"#",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"x",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"1",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"0",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"F",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"F",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"F",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"F",   1'b0, ROW_SILENT,  NO_ITEM},
		'{";",   1'b1, ROW_PREDICT, NO_ITEM},
		// second ampersand is just a name character, so the name is unknown
		'{"&",   1'b0, ROW_SILENT,  NO_ITEM},
		'{"&",   1'b0, ROW_SILENT,  NO_ITEM},
		'{";",   1'b1, ROW_TYPED,   '{8'h00, 1'b1, ERR_UNKNOWN}}
	};

	// Random phases: byte limit for each, and how many raw bytes to send under it
	localparam int unsigned PHASE_LIMIT [7] = '{4096, 1, 65535, 5, 2, 24, 4096};
	localparam int unsigned PHASE_ITEMS [7] = '{50, 30, 60, 40, 25, 40, 30};

	// Code points on or next to a range boundary
	localparam int unsigned ODD_POINTS [16] = '{
		32'h0, 32'h9, 32'hA, 32'hD, 32'h1F, 32'h20, 32'hD7FF, 32'hD800,
		32'hDFFF, 32'hE000, 32'hFFFD, 32'hFFFE, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000
	};

	string ent_names [5] = '{"lt", "gt", "amp", "quot", "apos"};
	// letters that make near misses of the named entities likely
	string name_chars_pool = "aglmopqstux";
	string unterm_pool = "#xX1aAlt&g";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	xed_in_if  raw_ch ();
	xed_out_if dec_ch ();

	xml_entity_decoder_utf8 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw_ch),
		.decoded   (dec_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Decoder state as the testbench tracks it
	// ---------------------------------------------------------------
	logic [15:0] byte_limit;
	logic        ent_open;     // between '&' and ';'
	logic [2:0]  ent_len;      // chars after '&', sticks at 7
	logic [31:0] name_sr;      // last four name chars
	logic        is_numeric;   // '#' right after '&'
	logic        is_hex;
	logic        got_digit;
	logic [20:0] cp_acc;       // code point so far
	logic        held_bad;     // digit error waiting for ';'
	logic [16:0] out_count;    // decoded bytes in this value
	logic        skipping;     // rest of value dropped after an error

	dec_item_t   step_bytes [$];   // results of the byte just accepted
	dec_item_t   due_bytes [$];    // results still to come out, oldest first
	logic [7:0]  value_bytes [$];  // raw bytes of the value being built

	int unsigned value_count;
	int unsigned bytes_sent;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned err_tally [5];
	int unsigned cycle_cnt = 0;

	function automatic void clear_entity();
		ent_open   = 1'b0;
		ent_len    = '0;
		name_sr    = '0;
		is_numeric = 1'b0;
		is_hex     = 1'b0;
		got_digit  = 1'b0;
		cp_acc     = '0;
		held_bad   = 1'b0;
	endfunction

	function automatic void close_value();
		clear_entity();
		out_count = '0;
		skipping  = 1'b0;
	endfunction

	function automatic void emit(logic [7:0] data, logic eov, xed_err_t err);
		dec_item_t r;
		r.data = data;
		r.eov  = eov;
		r.err  = err;
		step_bytes.insert(step_bytes.size(), r);
	endfunction

	// An error result ends the value; without the last flag the rest is dropped
	function automatic void raise_error(xed_err_t code, logic last);
		emit(8'h00, 1'b1, code);
		clear_entity();
		out_count = '0;
		skipping  = !last;
	endfunction

	function automatic bit is_xml_char(int unsigned c);
		return c == 32'h09 || c == 32'h0A || c == 32'h0D
			|| (c >= 32'h20 && c <= 32'hD7FF)
			|| (c >= 32'hE000 && c <= 32'hFFFD)
			|| (c >= 32'h10000 && c <= CODE_TOP);
	endfunction

	// Works out the results of one accepted raw byte into step_bytes
	function automatic void decode_byte(logic [7:0] b, logic last);
		int unsigned base;
		int unsigned digit;
		int unsigned cp;
		int unsigned n;
		logic [7:0]  enc [4];
		step_bytes.delete();
		if (skipping) begin
			if (last)
				close_value();
			return;
		end
		if (!ent_open) begin
			if (b == "&") begin
				clear_entity();
				ent_open = 1'b1;
				if (last)
					raise_error(ERR_UNTERM, last);
				return;
			end
			if (out_count + 1 > byte_limit) begin
				raise_error(ERR_TOO_LONG, last);
				return;
			end
			out_count++;
			emit(b, last, ERR_NONE);
			if (last)
				close_value();
			return;
		end
		if (b != ";") begin
			if (ent_len == 0 && b == "#") begin
				is_numeric = 1'b1;
			end else if (is_numeric) begin
				if (ent_len == 1 && (b == "x" || b == "X")) begin
					is_hex = 1'b1;
				end else begin
					base = is_hex ? 16 : 10;
					digit = base;
					got_digit = 1'b1;
					if (b >= "0" && b <= "9")
						digit = b - "0";
					else if (is_hex && b >= "a" && b <= "f")
						digit = b - "a" + 10;
					else if (is_hex && b >= "A" && b <= "F")
						digit = b - "A" + 10;
					// once a digit error is held the value stops moving
					if (!held_bad) begin
						if (digit >= base || cp_acc > (CODE_TOP - digit) / base)
							held_bad = 1'b1;
						else
							cp_acc = 21'(cp_acc * base + digit);
					end
				end
			end else begin
				name_sr = {name_sr[23:0], b};
			end
			if (ent_len < 7)
				ent_len++;
			if (last)
				raise_error(ERR_UNTERM, last);
			return;
		end

		// closing ';'
		n = 1;
		if (!is_numeric) begin
			if (ent_len == 2 && name_sr == "lt")
				enc[0] = "<";
			else if (ent_len == 2 && name_sr == "gt")
				enc[0] = ">";
			else if (ent_len == 3 && name_sr == "amp")
				enc[0] = "&";
			else if (ent_len == 4 && name_sr == "quot")
				enc[0] = "\"";
			else if (ent_len == 4 && name_sr == "apos")
				enc[0] = "'";
			else begin
				raise_error(ERR_UNKNOWN, last);
				return;
			end
		end else begin
			cp = cp_acc;
			if (held_bad) begin
				raise_error(ERR_BAD_REF, last);
				return;
			end
			if (!got_digit) begin
				// "&#x;" is a bad reference, a bare "&#;" an unknown entity
				if (is_hex)
					raise_error(ERR_BAD_REF, last);
				else
					raise_error(ERR_UNKNOWN, last);
				return;
			end
			if (!is_xml_char(cp)) begin
				raise_error(ERR_BAD_REF, last);
				return;
			end
			if (cp <= 32'h7F) begin
				enc[0] = 8'(cp);
			end else if (cp <= 32'h7FF) begin
				n = 2;
				enc[0] = 8'(32'hC0 | (cp >> 6));
				enc[1] = 8'(32'h80 | (cp & 32'h3F));
			end else if (cp <= 32'hFFFF) begin
				n = 3;
				enc[0] = 8'(32'hE0 | (cp >> 12));
				enc[1] = 8'(32'h80 | ((cp >> 6) & 32'h3F));
				enc[2] = 8'(32'h80 | (cp & 32'h3F));
			end else begin
				n = 4;
				enc[0] = 8'(32'hF0 | (cp >> 18));
				enc[1] = 8'(32'h80 | ((cp >> 12) & 32'h3F));
				enc[2] = 8'(32'h80 | ((cp >> 6) & 32'h3F));
				enc[3] = 8'(32'h80 | (cp & 32'h3F));
			end
		end
		// all or nothing against the byte limit
		if (out_count + n > byte_limit) begin
			raise_error(ERR_TOO_LONG, last);
			return;
		end
		for (int i = 0; i < n; i++)
			emit(enc[i], last && (i == n - 1), ERR_NONE);
		out_count = 17'(out_count + n);
		clear_entity();
		if (last)
			close_value();
	endfunction

	// ---------------------------------------------------------------
	// Building random values
	// ---------------------------------------------------------------
	function automatic void add_raw(logic [7:0] b);
		value_bytes.insert(value_bytes.size(), b);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_raw(s[i]);
	endfunction

	// Mostly well-formed text and references with random content, some broken
	// entities, and now and then a value that stops inside an entity
	function automatic void build_value();
		int unsigned tokens;
		int unsigned kind;
		int unsigned pick;
		int unsigned cp;
		string       digits;
		string       prefix;
		value_bytes.delete();
		tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
		for (int t = 0; t < tokens; t++) begin
			kind = $urandom_range(0, 23);
			if (kind < 6) begin
				repeat ($urandom_range(1, 4)) begin
					do
						pick = $urandom_range(0, 1) ? $urandom_range(8'h20, 8'h7E)
							: $urandom_range(0, 255);
					while (pick == "&");
					add_raw(8'(pick));
				end
			end else if (kind < 9) begin
				push_text({"&", ent_names[$urandom_range(0, 4)], ";"});
			end else if (kind < 17) begin
				case ($urandom_range(0, 9))
					0: cp = $urandom_range(0, 32'h7F);
					1: cp = $urandom_range(32'h80, 32'h7FF);
					2: cp = $urandom_range(32'h800, 32'hFFFF);
					3: cp = $urandom_range(32'h10000, CODE_TOP);
					4: cp = ODD_POINTS[$urandom_range(0, 15)];
					5: cp = $urandom;
					6: cp = $urandom_range(32'hA0, 32'h3000);
					default: cp = $urandom_range(32'h20, 32'h7E);
				endcase
				if ($urandom_range(0, 1)) begin
					digits = $sformatf("%0h", cp);
					for (int i = 0; i < digits.len(); i++)
						if (digits[i] >= "a" && $urandom_range(0, 1))
							digits[i] = digits[i] - 8'h20;
					prefix = $urandom_range(0, 1) ? "x" : "X";
				end else begin
					digits = $sformatf("%0d", cp);
					prefix = "";
				end
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2))
						digits = {"0", digits};
				push_text({"&#", prefix, digits, ";"});
			end else if (kind < 22) begin
				case ($urandom_range(0, 6))
					0: push_text("&;");
					1: push_text("&#;");
					2: begin
						if ($urandom_range(0, 1))
							push_text("&#x;");
						else
							push_text("&#X;");
					end
					3: begin
						add_raw("&");
						repeat ($urandom_range(1, 6))
							add_raw(name_chars_pool[$urandom_range(0, 10)]);
						add_raw(";");
					end
					4: begin
						// a stray byte among the digits
						push_text("&#");
						if ($urandom_range(0, 1))
							add_raw("x");
						repeat ($urandom_range(0, 2))
							add_raw("1");
						do
							pick = $urandom_range(0, 255);
						while (pick == ";");
						add_raw(8'(pick));
						add_raw(";");
					end
					5: begin
						add_raw("&");
						if ($urandom_range(0, 1))
							add_raw("a");
						push_text("&;");
					end
					default: begin
						add_raw("&");
						repeat ($urandom_range(1, 8)) begin
							do
								pick = $urandom_range(0, 255);
							while (pick == ";");
							add_raw(8'(pick));
						end
						add_raw(";");
					end
				endcase
			end else begin
				// value ends inside an entity
				add_raw("&");
				repeat ($urandom_range(0, 3))
					add_raw(unterm_pool[$urandom_range(0, 9)]);
				break;
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Raw byte side
	// ---------------------------------------------------------------
	// Entered just after a rising edge; returns at the edge that took the byte.
	task automatic send_byte(logic [7:0] b, logic last, row_check_e chk, dec_item_t want,
		bit steady);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			raw_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_ch.valid   <= 1'b1;
		raw_ch.in_byte <= b;
		raw_ch.last    <= last;
		@(posedge clk);
		while (!raw_ch.ready)
			@(posedge clk);
		bytes_sent++;
		decode_byte(b, last);
		case (chk)
			ROW_PREDICT: foreach (step_bytes[i]) due_bytes.insert(due_bytes.size(), step_bytes[i]);
			ROW_TYPED:   due_bytes.insert(due_bytes.size(), want);
			default:     ;
		endcase
	endtask

	task automatic send_value();
		bit steady;
		build_value();
		// about one value in four goes without gaps
		steady = ($urandom_range(0, 3) == 0);
		foreach (value_bytes[i])
			send_byte(value_bytes[i], i == value_bytes.size() - 1, ROW_PREDICT, NO_ITEM, steady);
		value_count++;
	endtask

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %0d: %s", mismatches, msg);
	endfunction

	// ---------------------------------------------------------------
	// Decoded side: random stalls, one long hold, and the checking
	// ---------------------------------------------------------------
	initial begin
		int unsigned stall;
		int unsigned run_left;
		bit          run_steady;
		bit          held;
		dec_item_t   want;
		run_left   = 0;
		run_steady = 1'b0;
		held       = 1'b0;
		dec_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// runs of results with or without stalls
			if (run_left == 0) begin
				run_left   = $urandom_range(1, 30);
				run_steady = ($urandom_range(0, 2) == 0);
			end
			run_left--;
			stall = run_steady ? 0 : $urandom_range(0, 5);
			// once in the whole test, hold off long enough to back the block up
			if (!held && results_seen >= 60) begin
				held  = 1'b1;
				stall = LONG_HOLD;
			end
			if (stall != 0) begin
				dec_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dec_ch.ready <= 1'b1;
			@(posedge clk);
			while (!dec_ch.valid)
				@(posedge clk);
			results_seen++;
			if (dec_ch.error_code <= 3'd4)
				err_tally[dec_ch.error_code]++;
			if (due_bytes.size() == 0) begin
				note_mismatch($sformatf("result %0d with nothing due: byte %02h eov %0d err %0d",
					results_seen, dec_ch.out_byte, dec_ch.end_of_value, dec_ch.error_code));
			end else begin
				want = due_bytes.pop_front();
				if (dec_ch.out_byte !== want.data || dec_ch.end_of_value !== want.eov
					|| dec_ch.error_code !== want.err)
					note_mismatch($sformatf(
						"result %0d: expected byte %02h eov %0d err %0d, got byte %02h eov %0d err %0d",
						results_seen, want.data, want.eov, want.err,
						dec_ch.out_byte, dec_ch.end_of_value, dec_ch.error_code));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				due_bytes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed table, random phases with limit changes
	// ---------------------------------------------------------------
	initial begin
		int unsigned target;
		raw_ch.valid   = 1'b0;
		raw_ch.in_byte = 8'h00;
		raw_ch.last    = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 16'h0000;
		arst_n         = 1'b0;
		value_count    = 0;
		bytes_sent     = 0;
		results_seen   = 0;
		mismatches     = 0;
		foreach (err_tally[i])
			err_tally[i] = 0;
		byte_limit = MAX_BYTES_RST;
		close_value();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].chk, DIR_ROWS[i].want,
				1'b0);

		foreach (PHASE_LIMIT[p]) begin
			if (p != 0) begin
				// limit changes only once the block has gone quiet
				raw_ch.valid <= 1'b0;
				while (due_bytes.size() != 0)
					@(posedge clk);
				repeat (SETTLE_CYCLES) @(posedge clk);
				cfg_we    <= 1'b1;
				cfg_wdata <= 16'(PHASE_LIMIT[p]);
				@(posedge clk);
				byte_limit = 16'(PHASE_LIMIT[p]);
				cfg_we <= 1'b0;
			end
			target = bytes_sent + PHASE_ITEMS[p];
			while (bytes_sent < target)
				send_value();
		end

		raw_ch.valid <= 1'b0;
		while (due_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d values, %0d raw bytes in, %0d results checked over %0d byte limits (1 to 65535)",
			value_count, bytes_sent, results_seen, $size(PHASE_LIMIT));
		$display("error results: unterminated %0d, unknown entity %0d, bad reference %0d, too long %0d",
			err_tally[ERR_UNTERM], err_tally[ERR_UNKNOWN], err_tally[ERR_BAD_REF],
			err_tally[ERR_TOO_LONG]);
		if (mismatches == 0 && due_bytes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
